### rtl/core/lir_pkg.sv
// Shared constants, codes and types for the linear interpolation resampler.
// No dependencies; every other file in rtl/core imports this package.
package lir_pkg;

   // result buffer depth (results kept per input beat)
   localparam int MAX_OUTPUTS = 32;
   localparam int RAM_AW      = $clog2(MAX_OUTPUTS);
   localparam int CNT_W       = $clog2(MAX_OUTPUTS + 1);

   localparam int SAMPLE_W  = 16;
   localparam int RATE_W    = 18;
   localparam int PHASE_W   = 19;
   localparam int CHAN_W    = 2;
   localparam int CSR_IDX_W = 2;
   localparam int PROD_W    = 36;   // a*dst + (b-a)*ph, signed
   localparam int STEP_W    = 5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_RATE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_RATE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT = 2'd2;

   localparam logic [RATE_W-1:0] RATE_RESET = 18'd44100;
   localparam logic [CHAN_W-1:0] CHAN_RESET = 2'd2;

   // divider step counts: quotient of a lerp fits 16 bits, remainder op is 18 bits
   localparam logic [STEP_W-1:0] LERP_STEPS = 5'd16;
   localparam logic [STEP_W-1:0] MOD_STEPS  = 5'd18;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef enum logic {
      OP_LERP = 1'b0,
      OP_MOD  = 1'b1
   } arith_op_type;

   typedef struct packed {
      logic         start;
      arith_op_type op;
   } arith_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } arith_stat_type;

   typedef struct packed {
      sample_type left;
      sample_type right;
   } frame_type;

endpackage

### rtl/core/lir_arith.sv
// Shared arithmetic unit: one 17x19 multiplier plus a restoring divider.
// Does exact lerp (a*dst + (b-a)*ph) / dst, or an 18-bit remainder. Uses lir_pkg.
module lir_arith (
   input  logic                          clock,
   input  logic                          reset,
   input  lir_pkg::arith_ctl_type        ctl,
   input  lir_pkg::sample_type           op_a,
   input  lir_pkg::sample_type           op_b,
   input  logic [lir_pkg::RATE_W-1:0]    op_x,
   input  logic [lir_pkg::RATE_W-1:0]    op_div,
   output lir_pkg::arith_stat_type       stat,
   output lir_pkg::sample_type           quot,
   output logic [lir_pkg::RATE_W-1:0]    remainder
);
   import lir_pkg::*;

   typedef enum logic [4:0] {
      AR_IDLE  = 5'b00001,
      AR_MUL_A = 5'b00010,
      AR_MUL_B = 5'b00100,
      AR_PREP  = 5'b01000,
      AR_DIV   = 5'b10000
   } ar_state_type;

   ar_state_type              state_ff, state_in;
   sample_type                a_ff, a_in, b_ff, b_in;
   logic [RATE_W-1:0]         x_ff, x_in, div_ff, div_in;
   logic signed [PROD_W-1:0]  acc_ff, acc_in;
   logic [RATE_W-1:0]         rem_ff, rem_in, sh_ff, sh_in;
   logic [SAMPLE_W-1:0]       q_ff, q_in;
   logic [STEP_W-1:0]         cnt_ff, cnt_in;
   logic                      neg_ff, neg_in;
   logic                      done_ff, done_in;

   logic signed [SAMPLE_W:0]  mul_x;
   logic signed [RATE_W:0]    mul_y;
   logic signed [PROD_W-1:0]  prod;
   logic [PROD_W-1:0]         mag;
   logic [RATE_W+1:0]         trial;

   // multiplier operands: a*dst first, then (b-a)*ph
   assign mul_x = (state_ff == AR_MUL_A) ? {a_ff[SAMPLE_W-1], a_ff}
                                         : ({b_ff[SAMPLE_W-1], b_ff} - {a_ff[SAMPLE_W-1], a_ff});
   assign mul_y = (state_ff == AR_MUL_A) ? {1'b0, div_ff} : {1'b0, x_ff};
   assign prod  = PROD_W'(mul_x) * PROD_W'(mul_y);

   assign mag   = acc_ff[PROD_W-1] ? PROD_W'(-acc_ff) : PROD_W'(acc_ff);
   assign trial = {1'b0, rem_ff, sh_ff[RATE_W-1]} - {2'b00, div_ff};

   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      x_in     = x_ff;
      div_in   = div_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      sh_in    = sh_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      done_in  = 1'b0;
      case (state_ff)
         AR_IDLE: begin
            if (ctl.start) begin
               a_in   = op_a;
               b_in   = op_b;
               x_in   = op_x;
               div_in = op_div;
               q_in   = '0;
               if (ctl.op == OP_LERP) begin
                  state_in = AR_MUL_A;
               end else begin
                  rem_in   = '0;
                  sh_in    = op_x;
                  cnt_in   = MOD_STEPS;
                  neg_in   = 1'b0;
                  state_in = AR_DIV;
               end
            end
         end
         AR_MUL_A: begin
            acc_in   = prod;
            state_in = AR_MUL_B;
         end
         AR_MUL_B: begin
            acc_in   = acc_ff + prod;
            state_in = AR_PREP;
         end
         AR_PREP: begin
            // |num| < dst * 2^16, so the top part already sits below the divisor
            neg_in   = acc_ff[PROD_W-1];
            rem_in   = mag[SAMPLE_W +: RATE_W];
            sh_in    = {mag[SAMPLE_W-1:0], {(RATE_W-SAMPLE_W){1'b0}}};
            cnt_in   = LERP_STEPS;
            state_in = AR_DIV;
         end
         AR_DIV: begin
            if (!trial[RATE_W+1]) begin
               rem_in = trial[RATE_W-1:0];
               q_in   = {q_ff[SAMPLE_W-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[RATE_W-2:0], sh_ff[RATE_W-1]};
               q_in   = {q_ff[SAMPLE_W-2:0], 1'b0};
            end
            sh_in  = {sh_ff[RATE_W-2:0], 1'b0};
            cnt_in = cnt_ff - STEP_W'(1);
            if (cnt_ff == STEP_W'(1)) begin
               done_in  = 1'b1;
               state_in = AR_IDLE;
            end
         end
         default: begin
            state_in = AR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AR_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      x_ff   <= x_in;
      div_ff <= div_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   // truncation toward zero: divide magnitudes, then restore the sign
   assign quot      = neg_ff ? sample_type'(-q_ff) : sample_type'(q_ff);
   assign remainder = rem_ff;
   assign stat.busy = (state_ff != AR_IDLE);
   assign stat.done = done_ff;

endmodule

### rtl/core/lir_result_ram.sv
// Result buffer: one write port, one registered read port, MAX_OUTPUTS frames.
// Depends on lir_pkg for depth and frame type.
module lir_result_ram (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [lir_pkg::RAM_AW-1:0]    wr_addr,
   input  lir_pkg::frame_type            wr_data,
   input  logic [lir_pkg::RAM_AW-1:0]    rd_addr,
   output lir_pkg::frame_type            rd_data
);
   import lir_pkg::*;

   frame_type mem_ff [MAX_OUTPUTS];
   frame_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/linear_interp_resampler.sv
// Top level of the linear interpolation resampler: sequencer, state and output stage.
// Depends on lir_pkg, lir_arith and lir_result_ram.
//
// Converts 16-bit mono or stereo PCM frames from source_rate to target_rate. Output
// frame d sits at source position d*source_rate/target_rate; its value is
// s0 + (s1 - s0) * phase/target_rate computed exactly and truncated toward zero.
// One input beat is taken, then req_stall stays high until every result it causes
// has been delivered. All results of a beat are first computed into a small
// buffer, because the dropped flag (more than MAX_OUTPUTS results) and run_end
// apply to the whole run; they are then streamed out. Timing is set by the single
// shared multiply/divide unit: each interpolated sample takes two multiplies, a sign
// step and a 16-step divide, and a stereo frame does this once per channel. A run
// that overflows the buffer adds an 18-step remainder that skips the lost positions.
// Each result beat then drains from the buffer through S_RD, S_LD and S_OUT, and
// waits in S_OUT while rsp_stall is high. With equal rates a frame passes straight
// through without interpolation. Rate registers holding 0 act as 1; channel_count
// 0 or 1 is mono, 2 or 3 is stereo.
// The configuration port may only be written while the block is idle.
module linear_interp_resampler (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [lir_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lir_pkg::RATE_W-1:0]      csr_write_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  lir_pkg::sample_type             req_in_left,
   input  lir_pkg::sample_type             req_in_right,
   input  logic                            req_final_frame,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output lir_pkg::sample_type             rsp_out_left,
   output lir_pkg::sample_type             rsp_out_right,
   output logic                            rsp_run_end,
   output logic                            rsp_dropped
);
   import lir_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_LOOP  = 8'b00000010,   // decide: next output, skip, or end of run
      S_LEFT  = 8'b00000100,
      S_RIGHT = 8'b00001000,
      S_MOD   = 8'b00010000,   // remainder for skipped positions
      S_RD    = 8'b00100000,
      S_LD    = 8'b01000000,
      S_OUT   = 8'b10000000
   } state_type;

   state_type              state_ff, state_in;

   // configuration
   logic [RATE_W-1:0]      src_ff, src_in, dst_ff, dst_in;
   logic [CHAN_W-1:0]      chan_ff, chan_in;

   // architectural state
   sample_type             held_l_ff, held_l_in, held_r_ff, held_r_in;
   logic                   have_held_ff, have_held_in;
   logic [PHASE_W-1:0]     phase_ff, phase_in;

   // current beat
   sample_type             cur_l_ff, cur_l_in, cur_r_ff, cur_r_in;
   logic                   fin_ff, fin_in;
   logic                   run2_ff, run2_in;    // second run: last frame against itself
   sample_type             res_l_ff, res_l_in;
   logic [CNT_W-1:0]       n_ff, n_in;
   logic                   drop_ff, drop_in;
   logic [RAM_AW-1:0]      rd_ff, rd_in;

   // output stage
   logic                   valid_ff, valid_in;
   sample_type             out_l_ff, out_l_in, out_r_ff, out_r_in;
   logic                   run_end_ff, run_end_in;
   logic                   dropped_ff, dropped_in;

   // arithmetic unit and buffer hookup
   arith_ctl_type          ar_ctl;
   arith_stat_type         ar_stat;
   sample_type             ar_a, ar_b, ar_quot;
   logic [RATE_W-1:0]      ar_x, ar_div, ar_rem;
   logic                   wr_en;
   logic [RAM_AW-1:0]      wr_addr;
   frame_type              wr_data, ram_rd;

   logic [RATE_W-1:0]      src_eff, dst_eff;
   logic                   stereo, accept, ph_lt, full, last_beat, run_done;
   sample_type             in_r, a_l, a_r;
   logic [PHASE_W-1:0]     ph_step, ph_wrap, mod_phase, run_phase;

   assign src_eff   = (src_ff == '0) ? RATE_W'(1) : src_ff;
   assign dst_eff   = (dst_ff == '0) ? RATE_W'(1) : dst_ff;
   assign stereo    = chan_ff[1];
   assign in_r      = stereo ? req_in_right : sample_type'(0);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign a_l       = run2_ff ? cur_l_ff : held_l_ff;
   assign a_r       = run2_ff ? cur_r_ff : held_r_ff;
   assign ph_lt     = phase_ff < PHASE_W'(dst_eff);
   assign full      = (n_ff == CNT_W'(MAX_OUTPUTS));
   assign ph_step   = phase_ff + PHASE_W'(src_eff);
   assign ph_wrap   = phase_ff - PHASE_W'(dst_eff);
   // phase after skipping: (src - (dst-ph) mod src) mod src
   assign mod_phase = (ar_rem == '0) ? '0 : PHASE_W'(src_eff - ar_rem);
   assign last_beat = ((CNT_W'(rd_ff) + CNT_W'(1)) == n_ff);

   // operand selection for the shared unit; the right channel starts from S_LEFT
   assign ar_a   = (state_ff == S_LEFT) ? a_r : a_l;
   assign ar_b   = (state_ff == S_LEFT) ? cur_r_ff : cur_l_ff;
   assign ar_x   = full ? (dst_eff - phase_ff[RATE_W-1:0]) : phase_ff[RATE_W-1:0];
   assign ar_div = full ? src_eff : dst_eff;

   always_comb begin
      state_in     = state_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      chan_in      = chan_ff;
      held_l_in    = held_l_ff;
      held_r_in    = held_r_ff;
      have_held_in = have_held_ff;
      phase_in     = phase_ff;
      cur_l_in     = cur_l_ff;
      cur_r_in     = cur_r_ff;
      fin_in       = fin_ff;
      run2_in      = run2_ff;
      res_l_in     = res_l_ff;
      n_in         = n_ff;
      drop_in      = drop_ff;
      rd_in        = rd_ff;
      valid_in     = valid_ff;
      out_l_in     = out_l_ff;
      out_r_in     = out_r_ff;
      run_end_in   = run_end_ff;
      dropped_in   = dropped_ff;
      ar_ctl.start = 1'b0;
      ar_ctl.op    = OP_LERP;
      wr_en        = 1'b0;
      wr_addr      = n_ff[RAM_AW-1:0];
      wr_data      = '{left: res_l_ff, right: ar_quot};
      run_done     = 1'b0;
      run_phase    = phase_ff;

      if (csr_write_en) begin
         case (csr_index)
            CSR_SOURCE_RATE:   src_in  = csr_write_data;
            CSR_TARGET_RATE:   dst_in  = csr_write_data;
            CSR_CHANNEL_COUNT: chan_in = csr_write_data[CHAN_W-1:0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cur_l_in = req_in_left;
               cur_r_in = in_r;
               fin_in   = req_final_frame;
               n_in     = '0;
               drop_in  = 1'b0;
               run2_in  = 1'b0;
               rd_in    = '0;
               if (src_eff == dst_eff) begin
                  // pass-through, state untouched
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  wr_data  = '{left: req_in_left, right: in_r};
                  n_in     = CNT_W'(1);
                  state_in = S_RD;
               end else if (have_held_ff) begin
                  state_in = S_LOOP;
               end else if (req_final_frame) begin
                  run2_in  = 1'b1;
                  state_in = S_LOOP;
               end else begin
                  // first frame of a buffer: just hold it
                  held_l_in    = req_in_left;
                  held_r_in    = in_r;
                  have_held_in = 1'b1;
               end
            end
         end
         S_LOOP: begin
            if (ph_lt) begin
               ar_ctl.start = 1'b1;
               if (full) begin
                  ar_ctl.op = OP_MOD;
                  drop_in   = 1'b1;
                  state_in  = S_MOD;
               end else begin
                  state_in = S_LEFT;
               end
            end else begin
               run_done  = 1'b1;
               run_phase = ph_wrap;
            end
         end
         S_LEFT: begin
            if (ar_stat.done) begin
               res_l_in = ar_quot;
               if (stereo) begin
                  ar_ctl.start = 1'b1;
                  state_in     = S_RIGHT;
               end else begin
                  wr_en    = 1'b1;
                  wr_data  = '{left: ar_quot, right: sample_type'(0)};
                  n_in     = n_ff + CNT_W'(1);
                  phase_in = ph_step;
                  state_in = S_LOOP;
               end
            end
         end
         S_RIGHT: begin
            if (ar_stat.done) begin
               wr_en    = 1'b1;
               n_in     = n_ff + CNT_W'(1);
               phase_in = ph_step;
               state_in = S_LOOP;
            end
         end
         S_MOD: begin
            if (ar_stat.done) begin
               run_done  = 1'b1;
               run_phase = mod_phase;
            end
         end
         S_RD: begin
            state_in = S_LD;
         end
         S_LD: begin
            valid_in   = 1'b1;
            out_l_in   = ram_rd.left;
            out_r_in   = ram_rd.right;
            run_end_in = last_beat;
            dropped_in = drop_ff;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               valid_in = 1'b0;
               if (last_beat) begin
                  state_in = S_IDLE;
               end else begin
                  rd_in    = rd_ff + RAM_AW'(1);
                  state_in = S_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // end of one interpolation run
      if (run_done) begin
         phase_in = run_phase;
         if (fin_ff && !run2_ff) begin
            run2_in  = 1'b1;
            state_in = S_LOOP;
         end else begin
            if (fin_ff) begin
               held_l_in    = '0;
               held_r_in    = '0;
               have_held_in = 1'b0;
               phase_in     = '0;
            end else begin
               held_l_in    = cur_l_ff;
               held_r_in    = cur_r_ff;
               have_held_in = 1'b1;
            end
            rd_in    = '0;
            state_in = (n_ff != '0) ? S_RD : S_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         src_ff       <= RATE_RESET;
         dst_ff       <= RATE_RESET;
         chan_ff      <= CHAN_RESET;
         held_l_ff    <= '0;
         held_r_ff    <= '0;
         have_held_ff <= 1'b0;
         phase_ff     <= '0;
         n_ff         <= '0;
         rd_ff        <= '0;
         valid_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         src_ff       <= src_in;
         dst_ff       <= dst_in;
         chan_ff      <= chan_in;
         held_l_ff    <= held_l_in;
         held_r_ff    <= held_r_in;
         have_held_ff <= have_held_in;
         phase_ff     <= phase_in;
         n_ff         <= n_in;
         rd_ff        <= rd_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_l_ff   <= cur_l_in;
      cur_r_ff   <= cur_r_in;
      fin_ff     <= fin_in;
      run2_ff    <= run2_in;
      res_l_ff   <= res_l_in;
      drop_ff    <= drop_in;
      out_l_ff   <= out_l_in;
      out_r_ff   <= out_r_in;
      run_end_ff <= run_end_in;
      dropped_ff <= dropped_in;
   end

   lir_arith u_arith (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ar_ctl),
      .op_a      (ar_a),
      .op_b      (ar_b),
      .op_x      (ar_x),
      .op_div    (ar_div),
      .stat      (ar_stat),
      .quot      (ar_quot),
      .remainder (ar_rem)
   );

   lir_result_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_ff),
      .rd_data (ram_rd)
   );

   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = valid_ff;
   assign rsp_out_left  = out_l_ff;
   assign rsp_out_right = out_r_ff;
   assign rsp_run_end   = run_end_ff;
   assign rsp_dropped   = dropped_ff;

   // shared unit is never restarted mid-operation
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ar_ctl.start |-> !ar_stat.busy)
      else $error("arith unit started while busy");

   // buffer never overfills
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= CNT_W'(MAX_OUTPUTS))
      else $error("result count beyond buffer depth");

   // a result beat is only shown from the drain stage
   a_valid_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == S_OUT))
      else $error("rsp_valid outside drain");

   // completions only land where the sequencer waits for them
   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      ar_stat.done |-> (state_ff == S_LEFT || state_ff == S_RIGHT || state_ff == S_MOD))
      else $error("arith completion not awaited");

   // last beat of a run releases the input side
   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_run_end) |=> (state_ff == S_IDLE))
      else $error("run_end beat did not return to idle");

endmodule
